[src/dafp_pkg.sv]
// Package for the direction angle pipeline: CORDIC datapath widths,
// the arctangent table in 1/65536 degree, and fixed angle constants.
// No dependencies.
`default_nettype none
package dafp_pkg;
	localparam int DegUnit   = 65536;
	localparam int GuardBits = 16;
	localparam int GainQ16   = 107922;
	localparam int TableLen  = 24;
	// Angle accumulator width: covers +-2048 degrees in 1/65536 degree
	localparam int ZW        = 28;

	typedef logic signed [ZW-1:0] angle_t;

	function automatic angle_t atan_deg(input int i);
		angle_t r;
		case (i)
			0: r = 28'sd2949120;  1: r = 28'sd1740967;  2: r = 28'sd919879;
			3: r = 28'sd466945;   4: r = 28'sd234379;   5: r = 28'sd117304;
			6: r = 28'sd58666;    7: r = 28'sd29335;    8: r = 28'sd14668;
			9: r = 28'sd7334;    10: r = 28'sd3667;    11: r = 28'sd1833;
			12: r = 28'sd917;    13: r = 28'sd458;     14: r = 28'sd229;
			15: r = 28'sd115;    16: r = 28'sd57;      17: r = 28'sd29;
			18: r = 28'sd14;     19: r = 28'sd7;       20: r = 28'sd4;
			21: r = 28'sd2;      22: r = 28'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	localparam angle_t Deg180 = angle_t'(180 * DegUnit);
	localparam angle_t Deg360 = angle_t'(360 * DegUnit);
endpackage
`default_nettype wire

[src/dafp_if.sv]
// Valid/ready channel carrying a packed payload.
// Depends on nothing; payload type given as a parameter.
`default_nettype none
interface dafp_if #(parameter type payload_t = logic) (input wire logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/dafp_cordic.sv]
// Pipelined vectoring CORDIC: one rotation per register stage.
// Uses dafp_pkg for the angle table. Stall via shared enable.
`default_nettype none
module dafp_cordic #(
	parameter int W      = 52,
	parameter int STAGES = 16,
	parameter int SW     = 4
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [W-1:0]    x_in,
	input  wire logic signed [W-1:0]    y_in,
	input  wire logic [SW-1:0]          side_in,
	output logic signed [W-1:0]         x_out,
	output dafp_pkg::angle_t            z_out,
	output logic [SW-1:0]               side_out
);
	import dafp_pkg::*;

	logic signed [W-1:0] x_s [STAGES+1];
	logic signed [W-1:0] y_s [STAGES+1];
	angle_t              z_s [STAGES+1];
	logic [SW-1:0]       d_s [STAGES+1];

	// Pre-rotate left half plane onto the right
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_in < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= Deg180;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
			d_s[0] <= side_in;
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_deg(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_deg(i);
				end
				d_s[i+1] <= d_s[i];
			end
		end
	end

	assign x_out    = x_s[STAGES];
	assign z_out    = z_s[STAGES];
	assign side_out = d_s[STAGES];
endmodule
`default_nettype wire

[src/direction_angles_from_two_points.sv]
// Direction angles from two 3D hit points.
// Input channel (in_ch): six signed coordinates, entry then exit hit.
// Output channel (out_ch): zenith and azimuth in 1/2^ANGLE_FRAC_BITS
// degree and a degenerate flag for coinciding hits.
// Zenith 0 points straight down (-z); azimuth is atan2(dy,dx) in [0,360).
// One pair per cycle is accepted while the receiver is not stalling.
// Two CORDICs run back to back: the first gives the azimuth and the
// horizontal length, the second the zenith; each stage is one rotation.
// The whole pipeline advances together: when the receiver stalls with a
// result waiting, every stage holds and in_ch.ready drops, so nothing is
// lost or repeated. Reset clears all valid bits; data registers are not reset.
`default_nettype none
module direction_angles_from_two_points #(
	parameter int COORD_WIDTH     = 16,
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int CORDIC_STAGES   = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	dafp_if.sink     in_ch,
	dafp_if.source   out_ch
);
	import dafp_pkg::*;

	localparam int DW  = COORD_WIDTH + 1;
	localparam int W   = DW + 19 + 2;
	localparam int LAT = 2 * CORDIC_STAGES + 6;
	localparam int SH  = 16 - ANGLE_FRAC_BITS;

	// in_ch.data: {first_x,first_y,first_z,second_x,second_y,second_z}
	// out_ch.data: {zenith_angle[14:0], azimuth_angle[15:0], degenerate}

	logic en;
	logic [LAT-1:0] vld_q;
	assign en           = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready  = en;
	assign out_ch.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_ch.valid};
	end

	// Stage 1: differences
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'($signed(in_ch.data[2*COORD_WIDTH+:COORD_WIDTH]))
			       - DW'($signed(in_ch.data[5*COORD_WIDTH+:COORD_WIDTH]));
			dy_s1 <= DW'($signed(in_ch.data[COORD_WIDTH+:COORD_WIDTH]))
			       - DW'($signed(in_ch.data[4*COORD_WIDTH+:COORD_WIDTH]));
			dz_s1 <= DW'($signed(in_ch.data[0+:COORD_WIDTH]))
			       - DW'($signed(in_ch.data[3*COORD_WIDTH+:COORD_WIDTH]));
		end
	end

	// Side info: {dz, degenerate, vertical}
	localparam int SW = DW + 2;
	logic [SW-1:0] side1_in, side1_out;
	logic signed [W-1:0] r_mag;
	angle_t za;
	assign side1_in = {dz_s1, (dx_s1 == 0 && dy_s1 == 0 && dz_s1 == 0),
		(dx_s1 == 0 && dy_s1 == 0)};

	dafp_cordic #(.W(W), .STAGES(CORDIC_STAGES), .SW(SW)) u_azi (
		.clk, .en,
		.x_in(W'(dx_s1) <<< GuardBits), .y_in(W'(dy_s1) <<< GuardBits),
		.side_in(side1_in), .x_out(r_mag), .z_out(za), .side_out(side1_out));

	// Stage: gain multiply of -dz, register azimuth alongside
	logic signed [W-1:0] zx_s2, r_s2;
	angle_t za_s2;
	logic [1:0] fl_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			zx_s2 <= -(W'($signed(side1_out[SW-1:2])) * W'(GainQ16));
			r_s2  <= r_mag;
			za_s2 <= za;
			fl_s2 <= side1_out[1:0];
		end
	end

	localparam int SW2 = ZW + 2 + 1;
	logic [SW2-1:0] side2_out;
	logic signed [W-1:0] unused_x;
	angle_t zz;
	logic dz_pos_s2;
	assign dz_pos_s2 = zx_s2 < 0;

	dafp_cordic #(.W(W), .STAGES(CORDIC_STAGES), .SW(SW2)) u_zen (
		.clk, .en, .x_in(zx_s2), .y_in(r_s2),
		.side_in({za_s2, fl_s2, dz_pos_s2}), .x_out(unused_x), .z_out(zz),
		.side_out(side2_out));

	// Stage: wrap azimuth, clamp zenith
	angle_t za_w, zz_c;
	angle_t za_f_s3, zz_f_s3;
	logic [2:0] fl_s3;
	always_comb begin
		za_w = side2_out[SW2-1:3];
		if (za_w < 0) za_w = za_w + Deg360;
		if (za_w >= Deg360) za_w = za_w - Deg360;
		if (za_w < 0) za_w = '0;
		zz_c = zz;
		if (zz_c < 0) zz_c = '0;
		if (zz_c > Deg180) zz_c = Deg180;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			za_f_s3 <= za_w;
			zz_f_s3 <= zz_c;
			fl_s3   <= side2_out[2:0];
		end
	end

	// Stage: round to output step
	localparam angle_t Half    = angle_t'(1) <<< (SH - 1);
	localparam angle_t FullOut = angle_t'(360) <<< ANGLE_FRAC_BITS;
	angle_t azr, zer;
	always_comb begin
		azr = (za_f_s3 + Half) >>> SH;
		if (azr >= FullOut) azr = azr - FullOut;
		zer = (zz_f_s3 + Half) >>> SH;
	end
	logic [14:0] zen_s4;
	logic [15:0] azi_s4;
	logic        deg_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			deg_s4 <= fl_s3[2];
			if (fl_s3[2]) begin
				zen_s4 <= '0;
				azi_s4 <= '0;
			end else if (fl_s3[1]) begin
				azi_s4 <= '0;
				zen_s4 <= fl_s3[0] ? 15'((180) << ANGLE_FRAC_BITS) : '0;
			end else begin
				azi_s4 <= azr[15:0];
				zen_s4 <= zer[14:0];
			end
		end
	end
	assign out_ch.data = {zen_s4, azi_s4, deg_s4};

	// Checks
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed under stall");
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data[0] |-> out_ch.data[31:1] == 0)
		else $error("degenerate with nonzero angles");
	a_zen_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.data[31:17] <= 15'(180 << ANGLE_FRAC_BITS))
		else $error("zenith above 180");
endmodule
`default_nettype wire
